// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mrc_pkg.sv
package mrc_pkg;

	localparam int MAX_NODES_DEF = 16;
	localparam int NODE_W        = 4;
	localparam int ROW_W         = 16;
	localparam int ACT_W         = 2;
	localparam int CFG_W         = 5;
	localparam int CFG_IDX_W     = 1;
	localparam int PATH_W        = 5;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd16;
	localparam logic [CFG_W-1:0] MAX_PATH_RST   = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH   = 1'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD_EDGE = 2'd0,
		ACT_COMPUTE  = 2'd1,
		ACT_CLEAR    = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_INIT_RD,
		ST_INIT_WR,
		ST_PROD_ROW,
		ST_PROD_LOAD,
		ST_PROD_K,
		ST_EM_ROW,
		ST_EM_LOAD,
		ST_EM_COL,
		ST_EM_OUT
	} state_t;

endpackage

// File: rtl/core/mrc_if.sv
interface mrc_item_if import mrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [NODE_W-1:0] edge_source;
	logic [NODE_W-1:0] edge_target;

	modport source (output valid, action, edge_source, edge_target, input ready);
	modport sink   (input valid, action, edge_source, edge_target, output ready);
endinterface

interface mrc_result_if import mrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] row_index;
	logic [ROW_W-1:0]  reach_row;
	logic [ROW_W-1:0]  mutual_row;
	logic              last_row;

	modport source (output valid, row_index, reach_row, mutual_row, last_row, input ready);
	modport sink   (input valid, row_index, reach_row, mutual_row, last_row, output ready);
endinterface

// File: rtl/core/mrc_ram.sv
module mrc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/mutual_reachability_closure_unit.sv
// Reachability closure of a small directed graph, with mutual-reachability rows.
//
// Requests arrive on the item channel (valid/ready). Action add edge stores
// source->target in the adjacency memory, writing the row in ST_ADD_WR; a self
// loop or an out-of-range node is dropped. Clear drops every adjacency row at
// once through per-row valid bits.
// Compute builds R = I | A | A^2 .. A^L in the power/reach memory, then emits
// one result per node row 0..n-1 on the result channel, last_row on row n-1.
// Compute, with n active nodes and L = max_path_length, seeds all n rows,
//   runs the product passes when L >= 2 and then forms the mutual rows;
//   any stall on the result side adds to its run time.
// Each product row sweeps the adjacency memory one row per cycle through its
// single read port; that sweep paces the product passes. Items are taken one at a time:
// ready is high only in the idle state, so it drops during an add edge write
// and for the whole of a compute.
// The result channel has an output register: a stalled receiver holds the row
// in place and the next row waits in the emit sequence until it is taken.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 node_count,
// 1 max_path_length); the user must use it only while idle: it is not enforced.
// Reset: adjacency empty, node_count 16, max_path_length 16, no result pending.
module mutual_reachability_closure_unit import mrc_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	mrc_item_if.sink             item,
	mrc_result_if.source         result
);

	localparam int IW  = $clog2(MAX_NODES);
	localparam int CAP = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0]     node_count_q;
	logic [PATH_W-1:0]    max_path_q;
	logic [MAX_NODES-1:0] adj_valid_q;
	logic [IW-1:0]        src_q, dst_q;
	logic [IW-1:0]        i_q, k_q;
	logic [PATH_W-1:0]    p_q;
	logic [MAX_NODES-1:0] pwr_q, rch_q, acc_q, mut_q;
	logic [IW-1:0]        adj_addr_s1;

	logic                 out_valid_q;
	logic [NODE_W-1:0]    row_index_q;
	logic [ROW_W-1:0]     reach_row_q, mutual_row_q;
	logic                 last_row_q;

	// memory ports
	logic                   adj_we;
	logic [IW-1:0]          adj_waddr, adj_raddr;
	logic [MAX_NODES-1:0]   adj_wdata, adj_rdata;
	logic                   pr_we;
	logic [IW-1:0]          pr_waddr, pr_raddr;
	logic [2*MAX_NODES-1:0] pr_wdata, pr_rdata;

	logic [MAX_NODES-1:0] adj_row, mask, pw_init, reach_init, acc_nxt;
	logic [MAX_NODES-1:0] pr_power, pr_reach;
	logic [MAX_NODES-1:0] one_hot_dst, one_hot_i;
	logic [6:0]           nc_w, nm_w;
	logic [IW-1:0]        n_m1, src_idx, dst_idx;
	logic                 edge_ok, last_i, last_k, em_fire;

	// Adjacency rows: one RAM, dropped rows read as zero via the valid bits.
	mrc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// Power and reach rows side by side: {reach, power}.
	mrc_ram #(.WIDTH(2*MAX_NODES), .DEPTH(MAX_NODES)) u_pr_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (pr_waddr),
		.wdata (pr_wdata),
		.raddr (pr_raddr),
		.rdata (pr_rdata)
	);

	assign pr_power = pr_rdata[MAX_NODES-1:0];
	assign pr_reach = pr_rdata[2*MAX_NODES-1:MAX_NODES];
	assign adj_row  = adj_valid_q[adj_addr_s1] ? adj_rdata : '0;

	// Active node count: zero counts as one, saturate at the row capacity.
	always_comb begin
		nc_w = 7'(node_count_q);
		if (nc_w == 7'd0) begin
			nm_w = 7'd0;
		end else if (nc_w > 7'(CAP)) begin
			nm_w = 7'(CAP) - 7'd1;
		end else begin
			nm_w = nc_w - 7'd1;
		end
		n_m1 = IW'(nm_w);
	end

	always_comb begin
		for (int b = 0; b < MAX_NODES; b++) begin
			mask[b] = (7'(b) <= nm_w);
		end
	end

	assign src_idx     = IW'(item.edge_source);
	assign dst_idx     = IW'(item.edge_target);
	assign edge_ok     = (item.edge_source != item.edge_target)
		&& (7'(item.edge_source) < 7'(MAX_NODES))
		&& (7'(item.edge_target) < 7'(MAX_NODES));
	assign one_hot_dst = {{(MAX_NODES-1){1'b0}}, 1'b1} << dst_q;
	assign one_hot_i   = {{(MAX_NODES-1){1'b0}}, 1'b1} << i_q;
	assign pw_init     = adj_row & mask;
	assign reach_init  = one_hot_i | ((max_path_q != '0) ? pw_init : '0);
	assign acc_nxt     = acc_q | (pwr_q[k_q] ? (adj_row & mask) : '0);
	assign last_i      = (i_q == n_m1);
	assign last_k      = (k_q == n_m1);
	assign em_fire     = (state_q == ST_EM_OUT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		adj_we     = 1'b0;
		adj_waddr  = src_q;
		adj_wdata  = adj_row | one_hot_dst;
		adj_raddr  = k_q;
		pr_we      = 1'b0;
		pr_waddr   = i_q;
		pr_wdata   = {rch_q | acc_nxt, acc_nxt};
		pr_raddr   = i_q;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				adj_raddr  = src_idx;
				if (item.valid) begin
					priority if (item.action == ACT_ADD_EDGE && edge_ok) begin
						state_d = ST_ADD_WR;
					end else if (item.action == ACT_COMPUTE) begin
						state_d = ST_INIT_RD;
					end
				end
			end
			ST_ADD_WR: begin
				adj_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_INIT_RD: begin
				adj_raddr = i_q;
				state_d   = ST_INIT_WR;
			end
			ST_INIT_WR: begin
				pr_we    = 1'b1;
				pr_wdata = {reach_init, pw_init};
				if (!last_i) begin
					state_d = ST_INIT_RD;
				end else if (max_path_q >= PATH_W'(2)) begin
					state_d = ST_PROD_ROW;
				end else begin
					state_d = ST_EM_ROW;
				end
			end
			ST_PROD_ROW: begin
				state_d = ST_PROD_LOAD;
			end
			ST_PROD_LOAD: begin
				adj_raddr = '0;
				state_d   = ST_PROD_K;
			end
			ST_PROD_K: begin
				adj_raddr = k_q + IW'(1);
				if (last_k) begin
					pr_we = 1'b1;
					if (last_i && p_q == max_path_q) begin
						state_d = ST_EM_ROW;
					end else begin
						state_d = ST_PROD_ROW;
					end
				end
			end
			ST_EM_ROW: begin
				state_d = ST_EM_LOAD;
			end
			ST_EM_LOAD: begin
				pr_raddr = '0;
				state_d  = ST_EM_COL;
			end
			ST_EM_COL: begin
				pr_raddr = k_q + IW'(1);
				if (last_k) begin
					state_d = ST_EM_OUT;
				end
			end
			ST_EM_OUT: begin
				if (em_fire) begin
					state_d = last_i ? ST_IDLE : ST_EM_ROW;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: configuration, row valid bits, counters, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			max_path_q   <= MAX_PATH_RST;
			adj_valid_q  <= '0;
			i_q          <= '0;
			k_q          <= '0;
			p_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NODE_COUNT: node_count_q <= cfg_data;
					REG_MAX_PATH:   max_path_q   <= PATH_W'(cfg_data);
					default:        ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					if (item.valid && item.action == ACT_CLEAR) begin
						adj_valid_q <= '0;
					end
				end
				ST_ADD_WR: begin
					adj_valid_q[src_q] <= 1'b1;
				end
				ST_INIT_WR: begin
					i_q <= last_i ? '0 : i_q + IW'(1);
					p_q <= PATH_W'(2);
				end
				ST_PROD_LOAD, ST_EM_LOAD: begin
					k_q <= '0;
				end
				ST_PROD_K: begin
					k_q <= k_q + IW'(1);
					if (last_k) begin
						i_q <= last_i ? '0 : i_q + IW'(1);
						if (last_i) begin
							p_q <= p_q + PATH_W'(1);
						end
					end
				end
				ST_EM_COL: begin
					k_q <= k_q + IW'(1);
				end
				ST_EM_OUT: begin
					if (em_fire) begin
						i_q <= i_q + IW'(1);
					end
				end
				default: ;
			endcase

			if (em_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		adj_addr_s1 <= adj_raddr;
		unique case (state_q)
			ST_IDLE: begin
				src_q <= src_idx;
				dst_q <= dst_idx;
			end
			ST_PROD_LOAD: begin
				pwr_q <= pr_power;
				rch_q <= pr_reach;
				acc_q <= '0;
			end
			ST_PROD_K: begin
				acc_q <= acc_nxt;
			end
			ST_EM_LOAD: begin
				rch_q <= pr_reach;
				mut_q <= '0;
			end
			ST_EM_COL: begin
				// column entry: does row k reach node i
				mut_q[k_q] <= rch_q[k_q] & pr_reach[i_q];
			end
			default: ;
		endcase
		if (em_fire) begin
			row_index_q  <= NODE_W'(i_q);
			reach_row_q  <= ROW_W'(rch_q[CAP-1:0]);
			mutual_row_q <= ROW_W'(mut_q[CAP-1:0]);
			last_row_q   <= last_i;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.row_index  = row_index_q;
	assign result.reach_row  = reach_row_q;
	assign result.mutual_row = mutual_row_q;
	assign result.last_row   = last_row_q;

endmodule

// File: rtl/core/mrc_checker.sv
`include "assert_macros.svh"

module mrc_checker import mrc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [NODE_W-1:0] res_row_index,
	input logic [ROW_W-1:0]  res_reach_row,
	input logic [ROW_W-1:0]  res_mutual_row,
	input logic              res_last_row
);

	logic [NODE_W-1:0] exp_row_q;

	// Track the row number the next result must carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_row_q <= '0;
		end else if (res_valid && res_ready) begin
			exp_row_q <= res_last_row ? '0 : res_row_index + NODE_W'(1);
		end
	end

	`MRC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`MRC_ASSERT_NOW(a_row_order, res_valid, res_row_index == exp_row_q, "rows out of order")
	`MRC_ASSERT_NOW(a_busy_mid_run, res_valid && !res_last_row, !item_ready, "request taken mid run")
	`MRC_ASSERT_NOW(a_row_shape, res_valid, res_reach_row[res_row_index] && res_mutual_row[res_row_index] && ((res_mutual_row & ~res_reach_row) == '0), "bad diagonal or mutual row")

endmodule

bind mutual_reachability_closure_unit mrc_checker u_mrc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_ready     (item.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_row_index  (result.row_index),
	.res_reach_row  (result.reach_row),
	.res_mutual_row (result.mutual_row),
	.res_last_row   (result.last_row)
);

// File: dv/mutual_reachability_closure_unit_test.sv
module mutual_reachability_closure_unit_test import mrc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Action code that the block has no meaning for; it must be swallowed silently.
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	// Cycles to let an add-edge or clear settle after the last row arrives.
	localparam int IDLE_GUARD      = 8;
	// Cycles to linger after the final row before declaring the outcome.
	localparam int TAIL_CYCLES     = 50;
	// Stop drawing random phases once this many requests have been accepted.
	localparam int TARGET_REQUESTS = 330;

	typedef struct {
		logic [NODE_W-1:0] row_index;
		logic [ROW_W-1:0]  reach_row;
		logic [ROW_W-1:0]  mutual_row;
		logic              last_row;
	} closure_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	mrc_item_if   req_ch ();
	mrc_result_if row_ch ();

	mutual_reachability_closure_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (req_ch),
		.result    (row_ch)
	);

	// Shadow of the block: adjacency rows and both registers, kept in step with
	// every accepted request and every register write.
	logic [ROW_W-1:0] adj_shadow [MAX_NODES_DEF];
	logic [CFG_W-1:0] nodes_shadow;
	logic [CFG_W-1:0] path_shadow;

	// Rows the closure is expected to emit, oldest first.
	closure_row_t pending_rows [$];

	// When set, neither side idles: back-to-back requests and rows.
	bit steady_flow;

	int errors;
	int requests_sent;
	int rows_checked;
	int settings_used;
	int action_hits [4];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap();
		return steady_flow ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic int active_nodes(logic [CFG_W-1:0] count);
		if (count == 0)
			return 1;
		if (count > MAX_NODES_DEF)
			return MAX_NODES_DEF;
		return count;
	endfunction

	// Build R = I | A | A^2 .. A^L over the active nodes, then queue one row per
	// node with its mutual-reachability row.
	function automatic void predict_closure();
		int               n;
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] power [MAX_NODES_DEF];
		logic [ROW_W-1:0] nxt   [MAX_NODES_DEF];
		logic [ROW_W-1:0] reach [MAX_NODES_DEF];
		logic [ROW_W-1:0] acc;
		closure_row_t     row;

		n = active_nodes(nodes_shadow);
		mask = ROW_W'((32'd1 << n) - 32'd1);
		for (int i = 0; i < n; i++) begin
			power[i] = adj_shadow[i] & mask;
			reach[i] = '0;
			reach[i][i] = 1'b1;
			if (path_shadow >= 1)
				reach[i] |= power[i];
		end
		// Powers beyond n add nothing new, but the block still sweeps them.
		for (int p = 2; p <= path_shadow; p++) begin
			for (int i = 0; i < n; i++) begin
				acc = '0;
				for (int k = 0; k < n; k++)
					if (power[i][k])
						acc |= adj_shadow[k] & mask;
				nxt[i] = acc;
			end
			for (int i = 0; i < n; i++) begin
				power[i] = nxt[i];
				reach[i] |= nxt[i];
			end
		end
		for (int i = 0; i < n; i++) begin
			row.row_index  = NODE_W'(i);
			row.reach_row  = reach[i];
			row.mutual_row = '0;
			for (int j = 0; j < n; j++)
				row.mutual_row[j] = reach[i][j] && reach[j][i];
			row.last_row = (i == n - 1);
			pending_rows.push_back(row);
		end
	endfunction

	function automatic void apply_request(logic [ACT_W-1:0] act, logic [NODE_W-1:0] src,
			logic [NODE_W-1:0] dst);
		case (act)
			ACT_ADD_EDGE: begin
				// Self loops never reach the matrix.
				if (src != dst)
					adj_shadow[src][dst] = 1'b1;
			end
			ACT_COMPUTE: begin
				predict_closure();
			end
			ACT_CLEAR: begin
				foreach (adj_shadow[i])
					adj_shadow[i] = '0;
			end
			default: begin
			end
		endcase
	endfunction

	// Offer one request after a random gap and hold it until the block takes it.
	// Valid is left high on return so a zero-gap follower keeps it asserted.
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] src,
			input logic [NODE_W-1:0] dst);
		int gap;

		gap = draw_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.edge_source <= src;
		req_ch.edge_target <= dst;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		apply_request(act, src, dst);
		action_hits[act]++;
		requests_sent++;
	endtask

	// Drop valid, let every expected row drain, then give a trailing add or
	// clear time to finish before anything touches the registers.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_NODE_COUNT)
			nodes_shadow = value;
		else
			path_shadow = value;
	endtask

	task automatic configure(input int nodes, input int path_len);
		wait_idle();
		set_register(REG_NODE_COUNT, CFG_W'(nodes));
		set_register(REG_MAX_PATH, CFG_W'(path_len));
		settings_used++;
	endtask

	// Mostly edges inside the active nodes; a little noise: undefined actions,
	// self loops and edges touching nodes the closure leaves out.
	task automatic send_random_edge(input int nodes);
		int pick;

		pick = $urandom_range(0, 19);
		if (pick == 0)
			send_request(ACT_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
		else if (pick == 1) begin
			automatic logic [NODE_W-1:0] node = NODE_W'($urandom);
			send_request(ACT_ADD_EDGE, node, node);
		end else if (pick <= 3)
			send_request(ACT_ADD_EDGE, NODE_W'($urandom), NODE_W'($urandom));
		else
			send_request(ACT_ADD_EDGE, NODE_W'($urandom_range(0, nodes - 1)),
				NODE_W'($urandom_range(0, nodes - 1)));
	endtask

	// Reset state: empty graph at 16 nodes, path length 16, so identity rows.
	task automatic test_reset_defaults();
		send_request(ACT_COMPUTE, '0, '0);
	endtask

	// Extreme node numbers, a self loop, an undefined action, a closure, then a clear and another closure.
	task automatic test_edge_cases();
		send_request(ACT_ADD_EDGE, 4'd0, 4'd15);
		send_request(ACT_ADD_EDGE, 4'd15, 4'd0);
		send_request(ACT_ADD_EDGE, 4'd5, 4'd5);
		send_request(ACT_UNUSED, 4'd15, 4'd15);
		send_request(ACT_ADD_EDGE, 4'd1, 4'd2);
		send_request(ACT_COMPUTE, 4'd15, 4'd15);
		send_request(ACT_CLEAR, 4'd0, 4'd0);
		send_request(ACT_COMPUTE, 4'd0, 4'd0);
	endtask

	// Register extremes: zero nodes and zero path length, saturating values,
	// edges beyond the active nodes, and a path length well above n.
	task automatic test_config_extremes();
		configure(0, 0);
		send_request(ACT_ADD_EDGE, 4'd0, 4'd1);
		send_request(ACT_COMPUTE, 4'd0, 4'd0);

		configure(31, 31);
		send_request(ACT_ADD_EDGE, 4'd0, 4'd15);
		send_request(ACT_ADD_EDGE, 4'd15, 4'd8);
		send_request(ACT_ADD_EDGE, 4'd8, 4'd0);
		send_request(ACT_COMPUTE, 4'd15, 4'd0);

		configure(3, 1);
		send_request(ACT_ADD_EDGE, 4'd2, 4'd7);
		send_request(ACT_ADD_EDGE, 4'd7, 4'd0);
		send_request(ACT_ADD_EDGE, 4'd1, 4'd2);
		send_request(ACT_COMPUTE, 4'd0, 4'd0);

		configure(4, 20);
		send_request(ACT_ADD_EDGE, 4'd3, 4'd0);
		send_request(ACT_COMPUTE, 4'd0, 4'd0);
		send_request(ACT_CLEAR, 4'd15, 4'd15);
		send_request(ACT_COMPUTE, 4'd0, 4'd0);
	endtask

	// Random phases: a fresh register setting, then rounds of optional clear,
	// a handful of edges and a closure request.
	task automatic test_random_graphs();
		int pick;
		int node_cfg;
		int path_cfg;
		int nodes;
		int rounds;

		while (requests_sent < TARGET_REQUESTS) begin
			// Keep large graphs on short paths and long paths on small graphs.
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				node_cfg = $urandom_range(0, 31);
				path_cfg = $urandom_range(0, 6);
			end else if (pick == 1) begin
				node_cfg = $urandom_range(1, 6);
				path_cfg = $urandom_range(13, 31);
			end else begin
				node_cfg = $urandom_range(1, 8);
				path_cfg = $urandom_range(0, 10);
			end
			configure(node_cfg, path_cfg);
			steady_flow = ($urandom_range(0, 3) == 0);
			nodes = active_nodes(CFG_W'(node_cfg));
			rounds = $urandom_range(1, 3);
			repeat (rounds) begin
				if ($urandom_range(0, 2) == 0)
					send_request(ACT_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
				repeat ($urandom_range(1, 2 * nodes))
					send_random_edge(nodes);
				// Now and then hold the sender until every row is back.
				if ($urandom_range(0, 4) == 0)
					wait_idle();
				send_request(ACT_COMPUTE, NODE_W'($urandom), NODE_W'($urandom));
			end
		end
		steady_flow = 1'b0;
	endtask

	function automatic void check_field(string name, logic [ROW_W-1:0] want_v,
			logic [ROW_W-1:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
		end
	endfunction

	// Row receiver: stall at random after each row, sometimes also while idle,
	// and check every accepted row against the oldest pending one.
	initial begin : row_checker
		closure_row_t want;
		int           stall;

		row_ch.ready = 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (row_ch.valid && row_ch.ready) begin
				if (pending_rows.size() == 0) begin
					errors++;
					$display("%0t: unexpected row, expected none, got index %0d reach %h mutual %h last %b",
						$time, row_ch.row_index, row_ch.reach_row, row_ch.mutual_row,
						row_ch.last_row);
				end else begin
					want = pending_rows.pop_front();
					check_field("row_index", ROW_W'(want.row_index), ROW_W'(row_ch.row_index));
					check_field("reach_row", want.reach_row, row_ch.reach_row);
					check_field("mutual_row", want.mutual_row, row_ch.mutual_row);
					check_field("last_row", ROW_W'(want.last_row), ROW_W'(row_ch.last_row));
					rows_checked++;
				end
				stall = draw_gap();
			end else if (!row_ch.valid && stall == 0 && !steady_flow && $urandom_range(0, 7) == 0)
				stall = draw_gap();
			if (stall > 0) begin
				row_ch.ready <= 1'b0;
				stall--;
			end else
				row_ch.ready <= 1'b1;
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_NODE_COUNT;
		cfg_data           = '0;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_ADD_EDGE;
		req_ch.edge_source = '0;
		req_ch.edge_target = '0;
		steady_flow        = 1'b0;
		nodes_shadow       = NODE_COUNT_RST;
		path_shadow        = MAX_PATH_RST;
		foreach (adj_shadow[i])
			adj_shadow[i] = '0;

		// Hold reset, release it on an edge, then let it settle.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_edge_cases();
		test_config_extremes();
		test_random_graphs();

		// Drain the last closure, then linger in case anything stray shows up.
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d edge loads, %0d closures, %0d clears, %0d undefined.",
			requests_sent, action_hits[ACT_ADD_EDGE], action_hits[ACT_COMPUTE],
			action_hits[ACT_CLEAR], action_hits[ACT_UNUSED]);
		$display("Checked %0d result rows over %0d register settings.", rows_checked,
			settings_used + 1);
		if (errors == 0)
			$display("mutual_reachability_closure_unit_test passed");
		else
			$display("mutual_reachability_closure_unit_test failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#100_000_000;
		$display("mutual_reachability_closure_unit_test failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/mrc_pkg.sv
rtl/core/mrc_if.sv
rtl/core/mrc_ram.sv
rtl/core/mutual_reachability_closure_unit.sv
rtl/core/mrc_checker.sv
dv/mutual_reachability_closure_unit_test.sv
